// File: rtl/core/fsds_pkg.sv
// shared types, constants and helpers for the seven-segment scanner
package fsds_pkg;

	// item actions
	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_SET     = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_INCR    = 2'd3
	} action_t;

	localparam int NUM_DIGITS = 4;

	localparam logic [7:0]  SEG_BLANK        = 8'hFF;
	localparam logic [3:0]  ENABLES_NONE     = 4'hF;
	localparam logic [15:0] SCAN_PERIOD_RST  = 16'd10;
	localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;
	localparam logic [3:0]  DIGIT_MAX        = 4'd9;

	// input item as seen on the port
	typedef struct packed {
		action_t    action;
		logic [7:0] thousands_in;
		logic [7:0] hundreds_in;
		logic [7:0] tens_in;
		logic [7:0] units_in;
	} in_item_t;

	// result item as seen on the port
	typedef struct packed {
		logic [7:0]  segment_pins;
		logic [3:0]  digit_enables;
		logic        refreshed;
		logic [1:0]  cursor_position;
		logic [3:0]  point_mask;
		logic [13:0] decimal_value;
	} out_item_t;

	// registered item with digits already reduced, index 0 units
	typedef struct packed {
		action_t                          action;
		logic [NUM_DIGITS-1:0][3:0]       digits;
	} item_s1_t;

	// remainder by ten of a byte through a reciprocal multiply
	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  quot;
		logic [7:0]  rem;
		prod = 16'(v) * 16'd205;
		quot = prod[15:11];
		rem  = v - 8'(quot) * 8'd10;
		return rem[3:0];
	endfunction

	// active-low segment pattern of a decimal digit, dp off
	function automatic logic [7:0] seg_decode(input logic [3:0] d);
		logic [7:0] code;
		unique case (d)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/core/four_digit_seven_segment_scanner_unit.sv
// Four-digit multiplexed seven-segment scanner. Takes one item per clock while
// the result register is not stalled: an accepted item is registered (digits
// reduced modulo ten on the way in), then applied to the display state and its
// result registered in the result register, and items may follow back to back.
// The rate is set by the state update loop in fsds_core. The output register
// lets a new item be taken while a finished result waits.
// The scan period resets to 10 ticks and may be changed through cfg_we and
// cfg_data while no item is in flight; a period of zero refreshes every tick.
module four_digit_seven_segment_scanner_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsds_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output fsds_pkg::out_item_t out_item
);
	import fsds_pkg::*;

	logic      valid_s1;
	item_s1_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t result;
	logic      fire;

	// stage one moves on when the result register is free or draining
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.action    <= in_item.action;
			item_s1.digits[3] <= mod10(in_item.thousands_in);
			item_s1.digits[2] <= mod10(in_item.hundreds_in);
			item_s1.digits[1] <= mod10(in_item.tens_in);
			item_s1.digits[0] <= mod10(in_item.units_in);
		end
	end

	fsds_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.fire     (fire),
		.item     (item_s1),
		.result   (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// a refresh selects exactly one digit
	a_refresh_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.refreshed |-> $countones(out_item_q.digit_enables) == 3)
		else $error("refresh did not select a single digit");

	// at most one point lit, and only under the cursor
	a_point_at_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0(out_item_q.point_mask) &&
			(out_item_q.point_mask == 4'd0 ||
			 out_item_q.point_mask[out_item_q.cursor_position]))
		else $error("point mask does not match cursor");

	// stored value stays a four-digit decimal
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_item_q.decimal_value <= 14'd9999)
		else $error("decimal value out of range");

	// a held result is not overwritten while stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !fire)
		else $error("result register overwritten while stalled");

endmodule

// File: rtl/core/fsds_core.sv
// display state registers and the single-pass update of one item
module fsds_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               fire,
	input  fsds_pkg::item_s1_t item,
	output fsds_pkg::out_item_t result
);
	import fsds_pkg::*;

	logic [15:0]                period_q;
	logic [NUM_DIGITS-1:0][3:0] digit_q;
	logic [3:0]                 point_q;
	logic [1:0]                 cursor_q;
	logic [1:0]                 scan_q;
	logic [15:0]                elapsed_q;
	logic [7:0]                 seg_q;
	logic [3:0]                 en_q;

	logic [NUM_DIGITS-1:0][3:0] digit_n;
	logic [3:0]                 point_n;
	logic [1:0]                 cursor_n;
	logic [1:0]                 scan_n;
	logic [15:0]                elapsed_n;
	logic [7:0]                 seg_n;
	logic [3:0]                 en_n;
	logic [15:0]                elapsed_inc;
	logic                       do_refresh;
	logic [7:0]                 scan_code;
	logic [3:0]                 cur_digit;
	logic [1:0]                 cursor_next;

	// scan period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= SCAN_PERIOD_RST;
		end else if (cfg_we) begin
			period_q <= cfg_data;
		end
	end

	// saturating tick count and refresh decision
	assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign do_refresh  = (item.action == ACT_TICK) && (elapsed_inc >= period_q);

	// pattern for the digit under scan
	always_comb begin
		scan_code = seg_decode(digit_q[scan_q]);
		if (point_q[scan_q]) begin
			scan_code[7] = 1'b0;
		end
	end

	assign cur_digit   = digit_q[cursor_q];
	assign cursor_next = cursor_q + 2'd1;

	// next state for the action
	always_comb begin
		digit_n   = digit_q;
		point_n   = point_q;
		cursor_n  = cursor_q;
		scan_n    = scan_q;
		elapsed_n = elapsed_q;
		seg_n     = seg_q;
		en_n      = en_q;
		unique case (item.action)
			ACT_TICK: begin
				elapsed_n = elapsed_inc;
				if (do_refresh) begin
					elapsed_n = '0;
					seg_n     = scan_code;
					en_n      = ~(4'b0001 << scan_q);
					scan_n    = scan_q + 2'd1;
				end
			end
			ACT_SET: begin
				digit_n = item.digits;
			end
			ACT_ADVANCE: begin
				point_n  = (point_q & ~(4'b0001 << cursor_q)) | (4'b0001 << cursor_next);
				cursor_n = cursor_next;
			end
			ACT_INCR: begin
				if (point_q[cursor_q]) begin
					digit_n[cursor_q] = (cur_digit == DIGIT_MAX) ? 4'd0 : cur_digit + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// state update per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q   <= '0;
			point_q   <= '0;
			cursor_q  <= '0;
			scan_q    <= '0;
			elapsed_q <= '0;
			seg_q     <= SEG_BLANK;
			en_q      <= ENABLES_NONE;
		end else if (fire) begin
			digit_q   <= digit_n;
			point_q   <= point_n;
			cursor_q  <= cursor_n;
			scan_q    <= scan_n;
			elapsed_q <= elapsed_n;
			seg_q     <= seg_n;
			en_q      <= en_n;
		end
	end

	// result from the state after the action
	always_comb begin
		result.segment_pins    = seg_n;
		result.digit_enables   = en_n;
		result.refreshed       = do_refresh;
		result.cursor_position = cursor_n;
		result.point_mask      = point_n;
		result.decimal_value   = 14'(digit_n[3]) * 14'd1000 + 14'(digit_n[2]) * 14'd100
			+ 14'(digit_n[1]) * 14'd10 + 14'(digit_n[0]);
	end

endmodule

// File: bench/four_digit_seven_segment_scanner_unit_tb.sv
// testbench for the four-digit seven-segment scanner with a predicting scoreboard
import fsds_pkg::*;

// tracks display state and holds the results each accepted item should produce
class display_tracker;
	logic [3:0]  digits [4];
	logic [3:0]  points;
	logic [1:0]  cursor;
	logic [1:0]  scan_pos;
	logic [15:0] elapsed;
	logic [15:0] period;
	logic [7:0]  seg_hold;
	logic [3:0]  en_hold;
	out_item_t   pins_due [$];
	int          misses;

	function new();
		foreach (digits[i]) digits[i] = '0;
		points   = '0;
		cursor   = '0;
		scan_pos = '0;
		elapsed  = '0;
		period   = SCAN_PERIOD_RST;
		seg_hold = SEG_BLANK;
		en_hold  = ENABLES_NONE;
		misses   = 0;
	endfunction

	function void set_period(logic [15:0] p);
		period = p;
	endfunction

	function int pending();
		return pins_due.size();
	endfunction

	// active-low pattern for one decimal digit, point dark
	function logic [7:0] glyph(logic [3:0] d);
		case (d)
			4'd0: return 8'hC0;
			4'd1: return 8'hF9;
			4'd2: return 8'hA4;
			4'd3: return 8'hB0;
			4'd4: return 8'h99;
			4'd5: return 8'h92;
			4'd6: return 8'h82;
			4'd7: return 8'hF8;
			4'd8: return 8'h80;
			default: return 8'h90;
		endcase
	endfunction

	// apply one accepted item and queue the result it must produce
	function void take_action(in_item_t it);
		out_item_t r;
		logic fired;
		fired = 1'b0;
		case (it.action)
			ACT_TICK: begin
				if (elapsed != ELAPSED_MAX) elapsed++;
				if (elapsed >= period) begin
					seg_hold = glyph(digits[scan_pos]);
					if (points[scan_pos]) seg_hold[7] = 1'b0;
					en_hold = ENABLES_NONE;
					en_hold[scan_pos] = 1'b0;
					scan_pos++;
					elapsed = '0;
					fired = 1'b1;
				end
			end
			ACT_SET: begin
				digits[3] = 4'(it.thousands_in % 8'd10);
				digits[2] = 4'(it.hundreds_in % 8'd10);
				digits[1] = 4'(it.tens_in % 8'd10);
				digits[0] = 4'(it.units_in % 8'd10);
			end
			ACT_ADVANCE: begin
				points[cursor] = 1'b0;
				cursor++;
				points[cursor] = 1'b1;
			end
			default: begin
				if (points[cursor])
					digits[cursor] = (digits[cursor] == DIGIT_MAX) ? 4'd0 : digits[cursor] + 4'd1;
			end
		endcase
		r.segment_pins    = seg_hold;
		r.digit_enables   = en_hold;
		r.refreshed       = fired;
		r.cursor_position = cursor;
		r.point_mask      = points;
		r.decimal_value   = 14'(int'(digits[3]) * 1000 + int'(digits[2]) * 100
			+ int'(digits[1]) * 10 + int'(digits[0]));
		pins_due.push_back(r);
	endfunction

	function void flag(string what, int want, int got);
		misses++;
		if (misses <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endfunction

	// compare one result against the oldest prediction
	function void compare_pins(out_item_t got);
		out_item_t want;
		if (pins_due.size() == 0) begin
			misses++;
			if (misses <= 10)
				$display("result with nothing pending: %0h", got);
			return;
		end
		want = pins_due.pop_front();
		if (got.segment_pins !== want.segment_pins)
			flag("segment_pins", want.segment_pins, got.segment_pins);
		if (got.digit_enables !== want.digit_enables)
			flag("digit_enables", want.digit_enables, got.digit_enables);
		if (got.refreshed !== want.refreshed)
			flag("refreshed", want.refreshed, got.refreshed);
		if (got.cursor_position !== want.cursor_position)
			flag("cursor_position", want.cursor_position, got.cursor_position);
		if (got.point_mask !== want.point_mask)
			flag("point_mask", want.point_mask, got.point_mask);
		if (got.decimal_value !== want.decimal_value)
			flag("decimal_value", want.decimal_value, got.decimal_value);
	endfunction
endclass

module four_digit_seven_segment_scanner_unit_tb;
	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 40;
	localparam int PHASE_ITEMS = 57;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;

	display_tracker tracker = new();
	int cycle_count = 0;
	bit calm = 0;
	bit hold_req = 0;

	four_digit_seven_segment_scanner_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.compare_pins(out_item);
	end

	// receiver: random stalls, one long hold when asked
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t make_item(action_t a, int th = 0, int hu = 0,
		int te = 0, int un = 0);
		in_item_t it;
		it.action       = a;
		it.thousands_in = 8'(th);
		it.hundreds_in  = 8'(hu);
		it.tens_in      = 8'(te);
		it.units_in     = 8'(un);
		return it;
	endfunction

	// ticks half the time, with edits mixed in
	function automatic in_item_t random_item();
		int pick;
		action_t a;
		pick = $urandom_range(0, 99);
		if (pick < 50) a = ACT_TICK;
		else if (pick < 65) a = ACT_SET;
		else if (pick < 85) a = ACT_ADVANCE;
		else a = ACT_INCR;
		return make_item(a, $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255));
	endfunction

	task automatic send_item(in_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		tracker.take_action(it);
	endtask

	task automatic idle_in(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	// reprogram the scan period once nothing is in flight
	task automatic write_period(logic [15:0] p);
		drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= p;
		@(negedge clk);
		cfg_we   <= 1'b0;
		tracker.set_period(p);
	endtask

	task automatic run_phase(logic [15:0] p, int n);
		write_period(p);
		for (int i = 0; i < n; i++) begin
			if (!calm && !hold_req && $urandom_range(0, 3) == 0)
				idle_in($urandom_range(1, 12));
			send_item(random_item());
		end
		idle_in(1);
	endtask

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edits at the reset period of ten ticks
		send_item(make_item(ACT_INCR));
		send_item(make_item(ACT_SET, 255, 0, 128, 9));
		send_item(make_item(ACT_SET, 0, 255, 10, 99));
		send_item(make_item(ACT_ADVANCE));
		send_item(make_item(ACT_INCR));
		send_item(make_item(ACT_INCR));
		send_item(make_item(ACT_ADVANCE));
		send_item(make_item(ACT_ADVANCE));
		send_item(make_item(ACT_ADVANCE));
		send_item(make_item(ACT_INCR));
		send_item(make_item(ACT_SET, 9, 9, 9, 9));
		send_item(make_item(ACT_INCR));
		repeat (10) send_item(make_item(ACT_TICK));
		idle_in(1);

		// zero period refreshes on every tick
		write_period(16'd0);
		repeat (4) send_item(make_item(ACT_TICK));
		idle_in(1);

		// random phases across periods; long output hold in the third
		run_phase(16'd1, PHASE_ITEMS);
		run_phase(16'd0, PHASE_ITEMS);
		hold_req = 1;
		run_phase(16'd3, PHASE_ITEMS);
		run_phase(16'hFFFF, PHASE_ITEMS);
		run_phase(16'd2, PHASE_ITEMS);
		run_phase(16'($urandom_range(4, 20)), PHASE_ITEMS);
		calm = 1;
		run_phase(16'd5, PHASE_ITEMS);

		drain();
		repeat (10) @(posedge clk);
		if (tracker.misses == 0 && tracker.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/core/fsds_pkg.sv
rtl/core/fsds_core.sv
rtl/core/four_digit_seven_segment_scanner_unit.sv
bench/four_digit_seven_segment_scanner_unit_tb.sv
